// ===== design/button_debounce_press_timer_assert.svh =====
// Assertion macros for the button debounce and press timer block.
`ifndef BUTTON_DEBOUNCE_PRESS_TIMER_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_TIMER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked at every rising edge outside reset.
`define BDPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define BDPT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BDPT_ASSERT(label, prop, msg)
`define BDPT_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== design/bdpt_pkg.sv =====
// Shared types and constants for the button debounce and press timer.
package bdpt_pkg;

  typedef enum logic [1:0] {
    MODE_RELEASED      = 2'd0,
    MODE_PRESSED_WAIT  = 2'd1,
    MODE_PRESSED       = 2'd2,
    MODE_RELEASED_WAIT = 2'd3
  } mode_t;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DEBOUNCE_W = 16;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd100;

endpackage

// ===== design/bdpt_if.sv =====
// Valid/ready channel interfaces for sample words and result words.
interface bdpt_in_if;
  logic                            valid;
  logic                            ready;
  logic [bdpt_pkg::TIME_W-1:0]     now_ms;
  logic                            btn_level;
  logic                            clear_duration;

  modport source (output valid, output now_ms, output btn_level,
                  output clear_duration, input ready);
  modport sink   (input valid, input now_ms, input btn_level,
                  input clear_duration, output ready);
endinterface

interface bdpt_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      mode;
  logic [bdpt_pkg::TIME_W-1:0]     press_duration;
  logic                            active;

  modport source (output valid, output mode, output press_duration,
                  output active, input ready);
  modport sink   (input valid, input mode, input press_duration,
                  input active, output ready);
endinterface

// ===== design/button_debounce_press_timer.sv =====
// Button debouncer with press-duration timer: input register, one-step update, result register.
// A sample word is held in the input register, then moves into the result register with its update.
// Throughput: one word per cycle while result words are taken; mode, deadline and duration update in one step.
// While a result word waits, the input register takes one more sample word; after that
// the input stalls until the result word is taken.
// Reset (synchronous, rst_n low) empties both registers, sets the mode to released,
// clears start time, deadline and duration, and sets the debounce time to 100 ms.
`include "button_debounce_press_timer_assert.svh"

module button_debounce_press_timer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bdpt_pkg::DEBOUNCE_W-1:0]   cfg_wdata,
  bdpt_in_if.sink                           in_ch,
  bdpt_out_if.source                        out_ch
);

  // Input register
  logic                            in_v_r;
  logic [bdpt_pkg::TIME_W-1:0]     in_now_r;
  logic                            in_level_r;
  logic                            in_clear_r;

  // Block state
  logic [bdpt_pkg::DEBOUNCE_W-1:0] debounce_r;
  bdpt_pkg::mode_t                 mode_r, mode_nxt;
  logic [bdpt_pkg::TIME_W-1:0]     start_r, start_nxt;
  logic [bdpt_pkg::TIME_W-1:0]     deadline_r, deadline_nxt;
  logic [bdpt_pkg::TIME_W-1:0]     held_r, held_nxt;

  // Result register
  logic                            out_v_r;
  bdpt_pkg::mode_t                 out_mode_r;
  logic [bdpt_pkg::TIME_W-1:0]     out_press_r;
  logic                            out_active_r;

  logic                            advance;
  logic                            expired;
  logic [bdpt_pkg::TIME_W-1:0]     rearm;

  // The held word moves into the result register whenever that register is free or emptying.
  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;

  assign expired = (in_now_r >= deadline_r);
  assign rearm   = in_now_r + {{(bdpt_pkg::TIME_W - bdpt_pkg::DEBOUNCE_W){1'b0}}, debounce_r};

  always_comb begin
    mode_nxt     = mode_r;
    start_nxt    = start_r;
    deadline_nxt = deadline_r;
    // A clear is applied first; a release in the same word then overrides it.
    held_nxt     = in_clear_r ? '0 : held_r;
    case (mode_r)
      bdpt_pkg::MODE_RELEASED: begin
        if (in_level_r) begin
          start_nxt    = in_now_r;
          deadline_nxt = rearm;
          mode_nxt     = bdpt_pkg::MODE_PRESSED_WAIT;
        end
      end
      bdpt_pkg::MODE_PRESSED_WAIT: begin
        if (expired) begin
          mode_nxt = bdpt_pkg::MODE_PRESSED;
        end
      end
      bdpt_pkg::MODE_PRESSED: begin
        if (!in_level_r) begin
          held_nxt     = in_now_r - start_r;
          deadline_nxt = rearm;
          mode_nxt     = bdpt_pkg::MODE_RELEASED_WAIT;
        end
      end
      default: begin
        if (expired) begin
          mode_nxt = bdpt_pkg::MODE_RELEASED;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      debounce_r <= bdpt_pkg::DEBOUNCE_RST;
      mode_r     <= bdpt_pkg::MODE_RELEASED;
      start_r    <= '0;
      deadline_r <= '0;
      held_r     <= '0;
    end else begin
      if (cfg_we) begin
        debounce_r <= cfg_wdata;
      end
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (advance) begin
        out_v_r    <= 1'b1;
        mode_r     <= mode_nxt;
        start_r    <= start_nxt;
        deadline_r <= deadline_nxt;
        held_r     <= held_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_now_r   <= in_ch.now_ms;
      in_level_r <= in_ch.btn_level;
      in_clear_r <= in_ch.clear_duration;
    end
    if (advance) begin
      out_mode_r   <= mode_nxt;
      out_press_r  <= held_nxt;
      out_active_r <= (mode_nxt != bdpt_pkg::MODE_RELEASED);
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.mode           = out_mode_r;
  assign out_ch.press_duration = out_press_r;
  assign out_ch.active         = out_active_r;

  `BDPT_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !in_v_r && !out_v_r, "registers not empty after reset")
  `BDPT_ASSERT(a_mode_holds, !advance |=> $stable(mode_r), "mode changed without a word")
  `BDPT_ASSERT(a_mode_steps, advance |=> (mode_r == $past(mode_r)) || (2'(mode_r) == 2'(2'($past(mode_r)) + 2'd1)), "mode skipped a step")
  `BDPT_ASSERT(a_held_stable, advance && !in_clear_r && !(mode_r == bdpt_pkg::MODE_PRESSED && !in_level_r) |=> $stable(held_r), "duration changed without clear or release")

endmodule
